// ===== hw/rtl/uvs_pkg.sv =====
`default_nettype none
package uvs_pkg;

  localparam int SEG_W      = 7;
  localparam int IDX_W      = 16;
  localparam int COORD_W    = 16;
  localparam int PHASE_W    = 32;
  localparam int WORK_FRAC  = 30;
  localparam int CORDIC_STEPS = 24;
  localparam int CORD_PER   = 3;
  localparam int CORD_STG   = CORDIC_STEPS / CORD_PER;
  localparam int PH_STG     = 4;
  localparam int PH_CHUNK   = PHASE_W / PH_STG;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LON = 2'd1;

  localparam logic [SEG_W-1:0] SEG_MIN   = 7'd4;
  localparam logic [SEG_W-1:0] SEG_RESET = 7'd15;

  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef struct packed {
    logic [1:0] corner;
    logic       in_range;
    logic       north;
    logic       south;
  } side_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [31:0] atan_turn(input int i);
    case (i)
      0:  return 32'sd536870912;
      1:  return 32'sd316933406;
      2:  return 32'sd167458907;
      3:  return 32'sd85004756;
      4:  return 32'sd42667331;
      5:  return 32'sd21354465;
      6:  return 32'sd10679838;
      7:  return 32'sd5340245;
      8:  return 32'sd2670163;
      9:  return 32'sd1335087;
      10: return 32'sd667544;
      11: return 32'sd333772;
      12: return 32'sd166886;
      13: return 32'sd83443;
      14: return 32'sd41722;
      15: return 32'sd20861;
      16: return 32'sd10430;
      17: return 32'sd5215;
      18: return 32'sd2608;
      19: return 32'sd1304;
      20: return 32'sd652;
      21: return 32'sd326;
      22: return 32'sd163;
      23: return 32'sd81;
      default: return 32'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/uvs_in_if.sv =====
`default_nettype none
interface uvs_in_if;
  import uvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] vertex_index;
  modport source (output valid, output vertex_index, input ready);
  modport sink   (input valid, input vertex_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/uvs_out_if.sv =====
`default_nettype none
interface uvs_out_if;
  import uvs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;
  logic [1:0]                corner;
  logic                      in_range;
  modport source (output valid, output x_coord, output y_coord, output z_coord,
                  output corner, output in_range, input ready);
  modport sink   (input valid, input x_coord, input y_coord, input z_coord,
                  input corner, input in_range, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/uvs_index_decode.sv =====
`default_nettype none
module uvs_index_decode (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [uvs_pkg::IDX_W-1:0]  idx,
  input  logic [uvs_pkg::SEG_W-1:0]  seg_m,
  input  logic [uvs_pkg::SEG_W-1:0]  seg_n,
  output logic                       out_valid,
  output logic [uvs_pkg::SEG_W-1:0]  ring,
  output logic [uvs_pkg::SEG_W-1:0]  lon,
  output uvs_pkg::side_t             side
);
  import uvs_pkg::*;

  // seven restoring steps of quad / N; remainder stays below N
  function automatic logic [13:0] row_chunk(input logic [6:0] rem_in,
                                           input logic [6:0] bits,
                                           input logic [6:0] den);
    logic [6:0] r;
    logic [6:0] q;
    logic [7:0] sh;
    r = rem_in;
    q = '0;
    for (int i = 6; i >= 0; i--) begin
      sh = {r, bits[i]};
      if (sh >= {1'b0, den}) begin
        sh   = sh - {1'b0, den};
        q[i] = 1'b1;
      end
      r = sh[6:0];
    end
    return {r, q};
  endfunction

  logic        v1, v2;
  logic [6:0]  rem1, qh1, ql1;
  logic [1:0]  c1, c2;
  logic [13:0] row2;
  logic [6:0]  n2;
  logic [13:0] ch1, ch2;

  assign ch1 = row_chunk(7'd0, idx[15:9], seg_n);
  assign ch2 = row_chunk(rem1, ql1, seg_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem1 <= ch1[13:7];
      qh1  <= ch1[6:0];
      ql1  <= idx[8:2];
      c1   <= idx[1:0];
      row2 <= {qh1, ch2[6:0]};
      n2   <= ch2[13:7];
      c2   <= c1;
    end
  end

  logic [6:0] ring_next, lon_next, n1;
  side_t      side_next;
  logic       top, bottom;

  always_comb begin
    n1        = (n2 == seg_n - 7'd1) ? 7'd0 : n2 + 7'd1;
    top       = (row2 == 14'd0);
    bottom    = (row2 == {7'd0, seg_m - 7'd1});
    side_next = '{corner: c2, in_range: (row2 < {7'd0, seg_m}), north: 1'b0, south: 1'b0};
    ring_next = row2[6:0];
    lon_next  = n2;
    if (top) begin
      side_next.north = ~c2[1];
      ring_next       = 7'd1;
      lon_next        = (c2 == 2'd2) ? n2 : n1;
    end else if (bottom) begin
      side_next.south = c2[1];
      lon_next        = (c2 == 2'd0) ? n1 : n2;
    end else begin
      ring_next = c2[1] ? row2[6:0] : row2[6:0] + 7'd1;
      lon_next  = (c2 == 2'd0 || c2 == 2'd3) ? n2 : n1;
    end
    if (!side_next.in_range) begin
      side_next.north = 1'b0;
      side_next.south = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ring <= ring_next;
      lon  <= lon_next;
      side <= side_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_phase_gen.sv =====
`default_nettype none
module uvs_phase_gen (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [uvs_pkg::SEG_W-1:0]   ring,
  input  logic [uvs_pkg::SEG_W-1:0]   lon,
  input  logic [uvs_pkg::SEG_W-1:0]   seg_m,
  input  logic [uvs_pkg::SEG_W-1:0]   seg_n,
  input  uvs_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [uvs_pkg::PHASE_W-1:0] tph,
  output logic [uvs_pkg::PHASE_W-1:0] pph,
  output uvs_pkg::side_t              out_side
);
  import uvs_pkg::*;

  // long division, numerator high part already below the divisor
  function automatic logic [PH_CHUNK+8:0] div_chunk(input logic [8:0] rem_in,
                                                   input logic [PH_CHUNK-1:0] bits,
                                                   input logic [8:0] den);
    logic [8:0]          r;
    logic [PH_CHUNK-1:0] q;
    logic [9:0]          sh;
    r = rem_in;
    q = '0;
    for (int i = PH_CHUNK - 1; i >= 0; i--) begin
      sh = {r, bits[i]};
      if (sh >= {1'b0, den}) begin
        sh   = sh - {1'b0, den};
        q[i] = 1'b1;
      end
      r = sh[8:0];
    end
    return {r, q};
  endfunction

  logic [8:0]         t_rem [0:PH_STG];
  logic [8:0]         p_rem [0:PH_STG];
  logic [PHASE_W-1:0] t_low [0:PH_STG];
  logic [PHASE_W-1:0] p_low [0:PH_STG];
  logic [PHASE_W-1:0] t_quo [0:PH_STG];
  logic [PHASE_W-1:0] p_quo [0:PH_STG];
  logic               vld   [0:PH_STG];
  side_t              sd    [0:PH_STG];
  logic [8:0]         t_den, p_den;

  assign t_den    = {1'b0, seg_m, 1'b0};
  assign p_den    = {2'b00, seg_n};
  assign t_rem[0] = {2'b00, ring};
  assign p_rem[0] = {2'b00, lon};
  assign t_low[0] = {{(PHASE_W-SEG_W){1'b0}}, seg_m};
  assign p_low[0] = {{(PHASE_W-SEG_W+1){1'b0}}, seg_n[SEG_W-1:1]};
  assign t_quo[0] = '0;
  assign p_quo[0] = '0;
  assign vld[0]   = in_valid;
  assign sd[0]    = in_side;

  for (genvar s = 0; s < PH_STG; s++) begin : g_stage
    logic [PH_CHUNK+8:0] tc, pc;
    assign tc = div_chunk(t_rem[s], t_low[s][PHASE_W-1 -: PH_CHUNK], t_den);
    assign pc = div_chunk(p_rem[s], p_low[s][PHASE_W-1 -: PH_CHUNK], p_den);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_rem[s+1] <= tc[PH_CHUNK+8:PH_CHUNK];
        p_rem[s+1] <= pc[PH_CHUNK+8:PH_CHUNK];
        t_quo[s+1] <= {t_quo[s][PHASE_W-PH_CHUNK-1:0], tc[PH_CHUNK-1:0]};
        p_quo[s+1] <= {p_quo[s][PHASE_W-PH_CHUNK-1:0], pc[PH_CHUNK-1:0]};
        t_low[s+1] <= {t_low[s][PHASE_W-PH_CHUNK-1:0], {PH_CHUNK{1'b0}}};
        p_low[s+1] <= {p_low[s][PHASE_W-PH_CHUNK-1:0], {PH_CHUNK{1'b0}}};
        sd[s+1]    <= sd[s];
      end
    end
  end

  assign out_valid = vld[PH_STG];
  assign tph       = t_quo[PH_STG];
  assign pph       = p_quo[PH_STG];
  assign out_side  = sd[PH_STG];

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_cordic.sv =====
`default_nettype none
module uvs_cordic (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [uvs_pkg::PHASE_W-1:0] tph,
  input  logic [uvs_pkg::PHASE_W-1:0] pph,
  input  uvs_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic signed [31:0]          ct,
  output logic signed [31:0]          st,
  output logic signed [31:0]          cp,
  output logic signed [31:0]          sp,
  output uvs_pkg::side_t              out_side
);
  import uvs_pkg::*;

  function automatic logic [95:0] rot_chunk(input logic signed [31:0] xi,
                                           input logic signed [31:0] yi,
                                           input logic signed [31:0] zi,
                                           input int base);
    logic signed [31:0] x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = zi;
    for (int j = 0; j < CORD_PER; j++) begin
      dx = y >>> (base + j);
      dy = x >>> (base + j);
      if (!z[31]) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_turn(base + j);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_turn(base + j);
      end
    end
    return {x, y, z};
  endfunction

  // lane 0 is theta, lane 1 is phi
  logic signed [31:0] cx [0:1][0:CORD_STG];
  logic signed [31:0] cy [0:1][0:CORD_STG];
  logic signed [31:0] cz [0:1][0:CORD_STG];
  logic [1:0]         qd [0:1][0:CORD_STG];
  logic               vld [0:CORD_STG];
  side_t              sd  [0:CORD_STG];

  assign cx[0][0] = CORDIC_GAIN;
  assign cx[1][0] = CORDIC_GAIN;
  assign cy[0][0] = '0;
  assign cy[1][0] = '0;
  assign cz[0][0] = $signed({2'b00, tph[29:0]});
  assign cz[1][0] = $signed({2'b00, pph[29:0]});
  assign qd[0][0] = tph[31:30];
  assign qd[1][0] = pph[31:30];
  assign vld[0]   = in_valid;
  assign sd[0]    = in_side;

  for (genvar s = 0; s < CORD_STG; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd[s+1] <= sd[s];
      end
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [95:0] rc;
      assign rc = rot_chunk(cx[l][s], cy[l][s], cz[l][s], s * CORD_PER);
      always_ff @(posedge clk) begin
        if (en) begin
          cx[l][s+1] <= rc[95:64];
          cy[l][s+1] <= rc[63:32];
          cz[l][s+1] <= rc[31:0];
          qd[l][s+1] <= qd[l][s];
        end
      end
    end
  end

  logic signed [31:0] c_next [0:1];
  logic signed [31:0] s_next [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      case (qd[l][CORD_STG])
        2'd0: begin
          c_next[l] = cx[l][CORD_STG];
          s_next[l] = cy[l][CORD_STG];
        end
        2'd1: begin
          c_next[l] = -cy[l][CORD_STG];
          s_next[l] = cx[l][CORD_STG];
        end
        2'd2: begin
          c_next[l] = -cx[l][CORD_STG];
          s_next[l] = -cy[l][CORD_STG];
        end
        default: begin
          c_next[l] = cy[l][CORD_STG];
          s_next[l] = -cx[l][CORD_STG];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[CORD_STG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ct       <= c_next[0];
      st       <= s_next[0];
      cp       <= c_next[1];
      sp       <= s_next[1];
      out_side <= sd[CORD_STG];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uvs_project.sv =====
`default_nettype none
module uvs_project #(
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [31:0]                ct,
  input  logic signed [31:0]                st,
  input  logic signed [31:0]                cp,
  input  logic signed [31:0]                sp,
  input  uvs_pkg::side_t                    in_side,
  output logic                              out_valid,
  output logic signed [uvs_pkg::COORD_W-1:0] x_coord,
  output logic signed [uvs_pkg::COORD_W-1:0] y_coord,
  output logic signed [uvs_pkg::COORD_W-1:0] z_coord,
  output logic [1:0]                        corner,
  output logic                              in_range
);
  import uvs_pkg::*;

  localparam int XY_SH = 2 * WORK_FRAC - COORD_FRAC_BITS;
  localparam int Z_SH  = WORK_FRAC - COORD_FRAC_BITS;
  localparam logic signed [63:0] LIM = 64'sd1 <<< COORD_FRAC_BITS;

  function automatic logic signed [63:0] round_sat(input logic signed [63:0] v,
                                                  input int sh);
    logic signed [63:0] r;
    r = (v + ((64'sd1 <<< sh) >>> 1)) >>> sh;
    if (r > LIM)  r = LIM;
    if (r < -LIM) r = -LIM;
    return r;
  endfunction

  logic               v1;
  logic signed [63:0] px, py, pz;
  side_t              sd1;

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= st * cp;
      py  <= st * sp;
      pz  <= 64'(ct);
      sd1 <= in_side;
    end
  end

  logic signed [63:0] rx, ry, rz;

  always_comb begin
    rx = round_sat(px, XY_SH);
    ry = round_sat(py, XY_SH);
    rz = round_sat(pz, Z_SH);
    if (!sd1.in_range) begin
      rx = '0;
      ry = '0;
      rz = '0;
    end else if (sd1.north) begin
      rx = '0;
      ry = '0;
      rz = LIM;
    end else if (sd1.south) begin
      rx = '0;
      ry = '0;
      rz = -LIM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_coord  <= rx[COORD_W-1:0];
      y_coord  <= ry[COORD_W-1:0];
      z_coord  <= rz[COORD_W-1:0];
      corner   <= sd1.in_range ? sd1.corner : 2'd0;
      in_range <= sd1.in_range;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/uv_sphere_vertex_generator_top.sv =====
// UV sphere vertex generator.
// vertex_in carries one word per vertex: its position in the quad list of a
// sphere with lat_segments bands and lon_segments ring segments, four
// positions per quad. vertex_out returns one word per input word, in order:
// unit-sphere x, y, z (signed, COORD_FRAC_BITS fraction bits), the corner
// within its quad and an in-range flag; out-of-range words come back zeroed.
// Configuration: cfg_write_en with cfg_index (0 = lat_segments,
// 1 = lon_segments) and cfg_data; values below 4 are used as 4, values above
// MAX_SEGMENTS as MAX_SEGMENTS. Write only while no word is in flight.
// Throughput: one word per cycle while vertex_out is not stalled. From
// acceptance to vertex_out.valid a word passes index decode (row/column long
// division), the angle-phase dividers, the two CORDIC rotors, and the product
// and rounding stage, in that order.
// Reset (synchronous, rst high) empties the pipeline and sets both segment
// counts to 15. When the receiver holds ready low with a word waiting, the
// whole pipeline freezes and vertex_in.ready drops; nothing is lost or
// repeated.
`default_nettype none
module uv_sphere_vertex_generator_top #(
  parameter int MAX_SEGMENTS    = 127,
  parameter int COORD_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uvs_pkg::SEG_W-1:0]     cfg_data,
  uvs_in_if.sink                        vertex_in,
  uvs_out_if.source                     vertex_out
);
  import uvs_pkg::*;

  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

  logic [SEG_W-1:0] lat_segments, lon_segments;
  logic [SEG_W-1:0] seg_m, seg_n;

  // register file, stored as written
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_segments <= SEG_RESET;
      lon_segments <= SEG_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_LAT: lat_segments <= cfg_data;
        CFG_LON: lon_segments <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] v);
    if (v < SEG_MIN) return SEG_MIN;
    if (v > SEG_MAX) return SEG_MAX;
    return v;
  endfunction

  assign seg_m = clamp_seg(lat_segments);
  assign seg_n = clamp_seg(lon_segments);

  // single pipeline enable: stall everything when the output word is held
  logic pipe_en;
  assign pipe_en         = !vertex_out.valid || vertex_out.ready;
  assign vertex_in.ready = pipe_en;

  logic             dec_valid;
  logic [SEG_W-1:0] dec_ring, dec_lon;
  side_t            dec_side;

  uvs_index_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (vertex_in.valid),
    .idx       (vertex_in.vertex_index),
    .seg_m     (seg_m),
    .seg_n     (seg_n),
    .out_valid (dec_valid),
    .ring      (dec_ring),
    .lon       (dec_lon),
    .side      (dec_side)
  );

  logic               ph_valid;
  logic [PHASE_W-1:0] ph_t, ph_p;
  side_t              ph_side;

  uvs_phase_gen u_phase (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (dec_valid),
    .ring      (dec_ring),
    .lon       (dec_lon),
    .seg_m     (seg_m),
    .seg_n     (seg_n),
    .in_side   (dec_side),
    .out_valid (ph_valid),
    .tph       (ph_t),
    .pph       (ph_p),
    .out_side  (ph_side)
  );

  logic               cor_valid;
  logic signed [31:0] cor_ct, cor_st, cor_cp, cor_sp;
  side_t              cor_side;

  uvs_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (ph_valid),
    .tph       (ph_t),
    .pph       (ph_p),
    .in_side   (ph_side),
    .out_valid (cor_valid),
    .ct        (cor_ct),
    .st        (cor_st),
    .cp        (cor_cp),
    .sp        (cor_sp),
    .out_side  (cor_side)
  );

  uvs_project #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_project (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (cor_valid),
    .ct        (cor_ct),
    .st        (cor_st),
    .cp        (cor_cp),
    .sp        (cor_sp),
    .in_side   (cor_side),
    .out_valid (vertex_out.valid),
    .x_coord   (vertex_out.x_coord),
    .y_coord   (vertex_out.y_coord),
    .z_coord   (vertex_out.z_coord),
    .corner    (vertex_out.corner),
    .in_range  (vertex_out.in_range)
  );

  // out-of-range words come out fully zeroed
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (vertex_out.valid && !vertex_out.in_range) |->
      (vertex_out.x_coord == '0 && vertex_out.y_coord == '0 &&
       vertex_out.z_coord == '0 && vertex_out.corner == 2'd0))
    else $error("out-of-range word not zeroed");

  // the z coordinate stays within the unit sphere's bounding box
  a_coord_bound: assert property (@(posedge clk) disable iff (rst)
    (vertex_out.valid && COORD_FRAC_BITS <= 14) |->
      ($signed(vertex_out.z_coord) <= $signed(COORD_W'(1 << COORD_FRAC_BITS)) &&
       $signed(vertex_out.z_coord) >= -$signed(COORD_W'(1 << COORD_FRAC_BITS))))
    else $error("z coordinate out of range");

  // a stall freezes the inner pipeline too
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !pipe_en |=> ($stable(dec_valid) && $stable(cor_valid)))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire
